// File: src/bdec_pkg.sv
// ----------------------------------------------------------------------------
// bdec_pkg
// Shared types, codes and the character lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdec_pkg;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CLS_SYM,
    CLS_PAD,
    CLS_SPACE,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      out_kind;
    logic       out_last;
  } out_item_t;

  // work left for the back part by one item
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data;
    logic       has_end;
    logic       err;
  } cmd_t;

  typedef struct packed {
    cls_e       cls;
    logic [5:0] val;
  } char_info_t;

  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t r;
    r.cls = CLS_BAD;
    r.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.cls = CLS_SYM;
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.cls = CLS_SYM;
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.cls = CLS_SYM;
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.cls = CLS_SYM;
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.cls = CLS_SYM;
      r.val = 6'd63;
    end else if (c == 8'h3D) begin
      r.cls = CLS_PAD;
    end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
      r.cls = CLS_SPACE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/bdec_front.sv
// ----------------------------------------------------------------------------
// bdec_front
// Accepts characters, classifies them, keeps the bit accumulator and emits
// one command per item that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire bdec_pkg::in_item_t in_item_i,
  output logic                    cmd_push_o,
  output bdec_pkg::cmd_t          cmd_o
);

  logic [7:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic       stopped_q, stopped_d;
  logic       failed_q, failed_d;

  bdec_pkg::char_info_t info;
  logic [13:0]          acc;
  logic [3:0]           total;
  logic [2:0]           sh;
  logic                 byte_out;

  assign info  = bdec_pkg::classify(in_item_i.in_char);
  assign acc   = {pend_bits_q, info.val};
  assign total = {1'b0, pend_cnt_q} + 4'd6;
  // remaining bit count, both when a byte goes out and when it does not
  assign sh    = total[2:0];

  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    stopped_d   = stopped_q;
    failed_d    = failed_q;
    byte_out    = 1'b0;
    if (!stopped_q) begin
      unique case (info.cls)
        bdec_pkg::CLS_PAD: begin
          stopped_d = 1'b1;
        end
        bdec_pkg::CLS_SPACE: begin
        end
        bdec_pkg::CLS_BAD: begin
          stopped_d = 1'b1;
          failed_d  = 1'b1;
        end
        bdec_pkg::CLS_SYM: begin
          byte_out    = total[3];
          pend_bits_d = acc[7:0] & ((8'd1 << sh) - 8'd1);
          pend_cnt_d  = sh;
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_o.has_byte = byte_out;
  assign cmd_o.data     = 8'(acc >> sh);
  assign cmd_o.has_end  = in_item_i.in_last;
  assign cmd_o.err      = failed_d;
  assign cmd_push_o     = accept_i && (byte_out || in_item_i.in_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      stopped_q   <= 1'b0;
      failed_q    <= 1'b0;
    end else if (accept_i) begin
      if (in_item_i.in_last) begin
        pend_bits_q <= '0;
        pend_cnt_q  <= '0;
        stopped_q   <= 1'b0;
        failed_q    <= 1'b0;
      end else begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
        stopped_q   <= stopped_d;
        failed_q    <= failed_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bdec_fifo.sv
// ----------------------------------------------------------------------------
// bdec_fifo
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bdec_pkg::cmd_t data_i,
  input  wire logic           pop_i,
  output bdec_pkg::cmd_t      data_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bdec_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/bdec_back.sv
// ----------------------------------------------------------------------------
// bdec_back
// Expands each command into its data byte and end status and holds the
// oldest result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bdec_pkg::cmd_t cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output bdec_pkg::out_item_t out_item_o
);

  logic                valid_q;
  logic                byte_done_q, byte_done_d;
  bdec_pkg::out_item_t out_q, out_d;
  logic                load;

  // output register is free when empty or being drained this cycle
  assign load    = !cmd_empty_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;
  assign out_item_o = out_q;

  always_comb begin
    cmd_pop_o   = 1'b0;
    byte_done_d = byte_done_q;
    out_d       = out_q;
    if (load) begin
      if (cmd_i.has_byte && !byte_done_q) begin
        out_d.out_byte = cmd_i.data;
        out_d.out_kind = bdec_pkg::KIND_DATA;
        out_d.out_last = 1'b0;
        if (cmd_i.has_end) begin
          byte_done_d = 1'b1;
        end else begin
          cmd_pop_o = 1'b1;
        end
      end else begin
        out_d.out_byte = 8'd0;
        out_d.out_kind = cmd_i.err ? bdec_pkg::KIND_END_ERR : bdec_pkg::KIND_END_OK;
        out_d.out_last = 1'b1;
        cmd_pop_o      = 1'b1;
        byte_done_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      byte_done_q <= 1'b0;
    end else begin
      byte_done_q <= byte_done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character per item, queue-style ports.
// ----------------------------------------------------------------------------
// Takes one base64 character per cycle (standard alphabet, '=' pad, space,
// tab, CR and LF skipped) and returns decoded bytes followed by an end status
// on the character flagged last. An item is accepted every cycle while full
// is low; the command of an item is written into the command queue on the
// accepting edge and loaded into the output register once that register is
// free. The result side drains one result per cycle while pop is high, so
// the last character of a text, which may give a byte and an end status,
// gives two results; the QueueDepth-entry command queue between the decoding
// front and the output stage absorbs that and any stall on pop.
`default_nettype none

module base64_stream_decoder #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire bdec_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output bdec_pkg::out_item_t      out_item_o
);

  logic           accept;
  logic           cmd_push, cmd_pop, cmd_full, cmd_empty;
  bdec_pkg::cmd_t cmd_in, cmd_out;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  bdec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  bdec_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  bdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// File: src/bdec_checker.sv
// ----------------------------------------------------------------------------
// bdec_checker
// Port-level checks of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                pop,
  input wire bdec_pkg::out_item_t out_item_o
);

  // end status and last flag always travel together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.out_last == (out_item_o.out_kind != bdec_pkg::KIND_DATA)))
    else $error("last flag does not match result kind");

  // end status results carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.out_last) |-> (out_item_o.out_byte == 8'd0))
    else $error("end status with nonzero byte");

  // no unused kind code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.out_kind == bdec_pkg::KIND_DATA ||
                out_item_o.out_kind == bdec_pkg::KIND_END_OK ||
                out_item_o.out_kind == bdec_pkg::KIND_END_ERR))
    else $error("illegal result kind");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

endmodule

bind base64_stream_decoder bdec_checker u_bdec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

`default_nettype wire
